// ===== hw/rtl/takf_pkg.sv =====
// takf_pkg: shared types, constants and helpers of the tilt angle kalman filter
// used by takf_csr, takf_mul, takf_div and tilt_angle_kalman_filter
`default_nettype none

package takf_pkg;

   localparam int COV_FRAC_BITS = 30;
   localparam int CFG_W         = 30;
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;
   localparam int WIDE_W        = 40;
   localparam int OPND_W        = 34;
   localparam int MAG_W         = OPND_W - 1;
   localparam int PROD_W        = 2 * MAG_W;
   localparam int MRES_W        = 36;

   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef logic signed [OPND_W-1:0] opnd_type;
   typedef logic signed [MRES_W-1:0] mres_type;
   typedef logic        [CFG_W-1:0]  cfg_reg_type;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
   localparam wide_type SAT_HI = 40'sh00_7FFF_FFFF;
   localparam wide_type SAT_LO = 40'shFF_8000_0000;

   // one in covariance format, saturated to 32 bits
   localparam logic signed [31:0] COV_ONE = (COV_FRAC_BITS >= 31) ? S32_MAX
                                          : 32'(64'd1 << COV_FRAC_BITS);

   localparam cfg_reg_type STEP_TIME_RST   = 30'd5368709;
   localparam cfg_reg_type ANGLE_NOISE_RST = 30'd10737;
   localparam cfg_reg_type BIAS_NOISE_RST  = 30'd10737;
   localparam cfg_reg_type MEAS_NOISE_RST  = 30'd107374182;

   typedef enum logic [1:0] {
      REG_STEP_TIME,
      REG_ANGLE_NOISE,
      REG_BIAS_NOISE,
      REG_MEAS_NOISE
   } reg_idx_type;

   typedef struct packed {
      cfg_reg_type step_time;
      cfg_reg_type angle_noise;
      cfg_reg_type bias_noise;
      cfg_reg_type meas_noise;
   } cfg_type;

   typedef struct packed {
      logic     issue;
      opnd_type a;
      opnd_type b;
   } mul_req_type;

   typedef struct packed {
      logic                start;
      logic signed [31:0]  num;
      logic        [32:0]  den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] quotient;
   } div_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RATE,
      ST_PB,
      ST_PBA,
      ST_P12,
      ST_P11,
      ST_S,
      ST_D1,
      ST_D1W,
      ST_D2,
      ST_D2W,
      ST_C1,
      ST_C2,
      ST_C3,
      ST_C4,
      ST_C5,
      ST_C6,
      ST_OUT
   } state_type;

   function automatic wide_type sx32(input logic signed [31:0] v);
      sx32 = {{(WIDE_W-32){v[31]}}, v};
   endfunction

   function automatic wide_type sxm(input mres_type v);
      sxm = {{(WIDE_W-MRES_W){v[MRES_W-1]}}, v};
   endfunction

   function automatic wide_type zxc(input cfg_reg_type v);
      zxc = {{(WIDE_W-CFG_W){1'b0}}, v};
   endfunction

   function automatic logic signed [31:0] sat32(input wide_type v);
      if (v > SAT_HI) begin
         sat32 = S32_MAX;
      end else if (v < SAT_LO) begin
         sat32 = S32_MIN;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

   function automatic opnd_type op32(input logic signed [31:0] v);
      op32 = {{(OPND_W-32){v[31]}}, v};
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tilt_angle_kalman_filter.sv =====
// tilt_angle_kalman_filter: angle and gyro bias kalman filter, top level and sequencer
// depends on takf_pkg, takf_csr, takf_mul and takf_div
//
// usage
//   req channel: one transfer per sample, req_tdata = measured angle and gyro rate
//   (signed q16.16). rsp channel: one transfer per sample, rsp_tdata = filtered
//   angle and bias-corrected rate (signed q16.16, saturated).
//   csr apb port: step time and the three noise variances, unsigned q0.30, at 0x0..0xc.
//   write them only while the filter is idle.
// sequencing
//   a sample is processed by one shared multiplier and a one-bit-per-cycle divider
//   under a sequencer. when the innovation variance is not positive the gain
//   divisions are skipped. req_tready is high only when the sequencer is idle,
//   so a new sample is not taken before the last one has left its result step.
// reset and stall
//   reset clears the estimates to zero, the covariance entries to one and the
//   registers to their defaults. a result waits in an output register; the next
//   sample is accepted meanwhile and held at its last step until rsp is free.
`default_nettype none

module tilt_angle_kalman_filter import takf_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [63:0]           req_tdata,   // measured_angle, gyro_rate
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [63:0]           rsp_tdata,   // filtered_angle, corrected_rate
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type     cfg;
   mul_req_type mul_req;
   mres_type    mul_res;
   div_req_type div_req;
   div_rsp_type div_rsp;

   state_type state_ff, state_in;

   logic signed [31:0] th_ff, th_in, w_ff, w_in;
   logic signed [31:0] angle_ff, angle_in, bias_ff, bias_in;
   logic signed [31:0] caa_ff, caa_in, cab_ff, cab_in, cba_ff, cba_in, cbb_ff, cbb_in;
   logic signed [31:0] xe1_ff, xe1_in;
   logic signed [31:0] pe11_ff, pe11_in, pe12_ff, pe12_in;
   logic signed [31:0] pe21_ff, pe21_in, pe22_ff, pe22_in;
   logic signed [31:0] k1_ff, k1_in, k2_ff, k2_in;
   wide_type           acc_ff, acc_in;
   logic signed [33:0] s_ff, s_in;
   logic signed [32:0] e_ff, e_in;
   logic        [63:0] rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff, rsp_valid_in;

   wide_type r_w;
   wide_type w_minus_b;
   wide_type s_sum;
   wide_type e_sum;
   opnd_type dt_op;
   opnd_type e_op;
   logic     s_nonpos;
   logic     out_free;

   takf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   takf_mul u_mul (
      .clock  (clock),
      .req    (mul_req),
      .result (mul_res)
   );

   takf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign r_w       = sxm(mul_res);
   assign w_minus_b = sx32(w_ff) - sx32(bias_ff);
   assign s_sum     = sx32(pe11_ff) + zxc(cfg.meas_noise);
   assign e_sum     = sx32(th_ff) - sx32(xe1_ff);
   assign dt_op     = {{(OPND_W-CFG_W){1'b0}}, cfg.step_time};
   assign e_op      = {e_ff[32], e_ff};
   assign s_nonpos  = s_ff[33] || (s_ff == '0);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_RATE;
         ST_RATE: state_in = ST_PB;
         ST_PB:   state_in = ST_PBA;
         ST_PBA:  state_in = ST_P12;
         ST_P12:  state_in = ST_P11;
         ST_P11:  state_in = ST_S;
         ST_S:    state_in = ST_D1;
         ST_D1:   state_in = s_nonpos ? ST_C1 : ST_D1W;
         ST_D1W:  if (div_rsp.done) state_in = ST_D2;
         ST_D2:   state_in = ST_D2W;
         ST_D2W:  if (div_rsp.done) state_in = ST_C1;
         ST_C1:   state_in = ST_C2;
         ST_C2:   state_in = ST_C3;
         ST_C3:   state_in = ST_C4;
         ST_C4:   state_in = ST_C5;
         ST_C5:   state_in = ST_C6;
         ST_C6:   state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath controls and next values
   always_comb begin
      mul_req      = '0;
      div_req      = '0;
      div_req.den  = s_ff[32:0];
      th_in        = th_ff;
      w_in         = w_ff;
      angle_in     = angle_ff;
      bias_in      = bias_ff;
      caa_in       = caa_ff;
      cab_in       = cab_ff;
      cba_in       = cba_ff;
      cbb_in       = cbb_ff;
      xe1_in       = xe1_ff;
      pe11_in      = pe11_ff;
      pe12_in      = pe12_ff;
      pe21_in      = pe21_ff;
      pe22_in      = pe22_ff;
      k1_in        = k1_ff;
      k2_in        = k2_ff;
      acc_in       = acc_ff;
      s_in         = s_ff;
      e_in         = e_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               th_in = req_tdata[31:0];
               w_in  = req_tdata[63:32];
            end
         end
         ST_RATE: begin
            mul_req = '{issue: 1'b1, a: dt_op, b: w_minus_b[OPND_W-1:0]};
         end
         ST_PB: begin
            mul_req = '{issue: 1'b1, a: dt_op, b: op32(cbb_ff)};
            xe1_in  = sat32(sx32(angle_ff) + r_w);
         end
         ST_PBA: begin
            mul_req = '{issue: 1'b1, a: dt_op, b: op32(cba_ff)};
            pe12_in = sat32(sx32(cab_ff) - r_w);
            pe21_in = sat32(sx32(cba_ff) - r_w);
            pe22_in = sat32(sx32(cbb_ff) + zxc(cfg.bias_noise));
         end
         ST_P12: begin
            mul_req = '{issue: 1'b1, a: dt_op, b: op32(pe12_ff)};
            acc_in  = sx32(caa_ff) - r_w + zxc(cfg.angle_noise);
         end
         ST_P11: begin
            pe11_in = sat32(acc_ff - r_w);
         end
         ST_S: begin
            s_in = s_sum[33:0];
            e_in = e_sum[32:0];
         end
         ST_D1: begin
            if (s_nonpos) begin
               k1_in = '0;
               k2_in = '0;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = pe11_ff;
            end
         end
         ST_D1W: begin
            if (div_rsp.done) k1_in = div_rsp.quotient;
         end
         ST_D2: begin
            div_req.start = 1'b1;
            div_req.num   = pe21_ff;
         end
         ST_D2W: begin
            if (div_rsp.done) k2_in = div_rsp.quotient;
         end
         ST_C1: begin
            mul_req = '{issue: 1'b1, a: op32(k1_ff), b: e_op};
         end
         ST_C2: begin
            mul_req  = '{issue: 1'b1, a: op32(k2_ff), b: e_op};
            angle_in = sat32(sx32(xe1_ff) + r_w);
         end
         ST_C3: begin
            mul_req = '{issue: 1'b1, a: op32(k1_ff), b: op32(pe11_ff)};
            bias_in = sat32(sx32(bias_ff) + r_w);
         end
         ST_C4: begin
            mul_req = '{issue: 1'b1, a: op32(k1_ff), b: op32(pe12_ff)};
            caa_in  = sat32(sx32(pe11_ff) - r_w);
         end
         ST_C5: begin
            mul_req = '{issue: 1'b1, a: op32(k2_ff), b: op32(pe11_ff)};
            cab_in  = sat32(sx32(pe12_ff) - r_w);
         end
         ST_C6: begin
            mul_req = '{issue: 1'b1, a: op32(k2_ff), b: op32(pe12_ff)};
            cba_in  = sat32(sx32(pe21_ff) - r_w);
         end
         ST_OUT: begin
            cbb_in = sat32(sx32(pe22_ff) - r_w);
            if (out_free) begin
               rsp_data_in  = {sat32(w_minus_b), angle_ff};
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_tready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         angle_ff     <= '0;
         bias_ff      <= '0;
         caa_ff       <= COV_ONE;
         cab_ff       <= COV_ONE;
         cba_ff       <= COV_ONE;
         cbb_ff       <= COV_ONE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         angle_ff     <= angle_in;
         bias_ff      <= bias_in;
         caa_ff       <= caa_in;
         cab_ff       <= cab_in;
         cba_ff       <= cba_in;
         cbb_ff       <= cbb_in;
      end
      th_ff       <= th_in;
      w_ff        <= w_in;
      xe1_ff      <= xe1_in;
      pe11_ff     <= pe11_in;
      pe12_ff     <= pe12_in;
      pe21_ff     <= pe21_in;
      pe22_ff     <= pe22_in;
      k1_ff       <= k1_in;
      k2_ff       <= k2_in;
      acc_ff      <= acc_in;
      s_ff        <= s_in;
      e_ff        <= e_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("filter ready again right after a transfer");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_D1W || state_ff == ST_D2W))
      else $error("divider finished outside a gain wait step");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && rsp_valid_ff && !rsp_tready |=> state_ff == ST_OUT)
      else $error("result step left while the output register was still full");

endmodule

`default_nettype wire

// ===== hw/rtl/takf_csr.sv =====
// takf_csr: apb register file holding step time and noise settings
// depends on takf_pkg
`default_nettype none

module takf_csr import takf_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx        = reg_idx_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_STEP_TIME:   cfg_in.step_time   = csr_pwdata[CFG_W-1:0];
            REG_ANGLE_NOISE: cfg_in.angle_noise = csr_pwdata[CFG_W-1:0];
            REG_BIAS_NOISE:  cfg_in.bias_noise  = csr_pwdata[CFG_W-1:0];
            REG_MEAS_NOISE:  cfg_in.meas_noise  = csr_pwdata[CFG_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_STEP_TIME:   csr_prdata = CSR_DATA_W'(cfg_ff.step_time);
         REG_ANGLE_NOISE: csr_prdata = CSR_DATA_W'(cfg_ff.angle_noise);
         REG_BIAS_NOISE:  csr_prdata = CSR_DATA_W'(cfg_ff.bias_noise);
         REG_MEAS_NOISE:  csr_prdata = CSR_DATA_W'(cfg_ff.meas_noise);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_time   <= STEP_TIME_RST;
         cfg_ff.angle_noise <= ANGLE_NOISE_RST;
         cfg_ff.bias_noise  <= BIAS_NOISE_RST;
         cfg_ff.meas_noise  <= MEAS_NOISE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/takf_mul.sv =====
// takf_mul: shared sign-magnitude multiplier with registered product
// rounds the product magnitude to nearest, ties away from zero; depends on takf_pkg
`default_nettype none

module takf_mul import takf_pkg::*; (
   input  wire logic        clock,
   input  wire mul_req_type req,
   output mres_type         result
);

   localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (COV_FRAC_BITS - 1);

   logic [MAG_W-1:0]  mag_a, mag_b;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              neg_ff, neg_in;
   logic [PROD_W-1:0] rnd;
   logic [MRES_W-1:0] rmag;
   opnd_type          neg_a, neg_b;

   assign neg_a = -req.a;
   assign neg_b = -req.b;
   assign mag_a = req.a[OPND_W-1] ? neg_a[MAG_W-1:0] : req.a[MAG_W-1:0];
   assign mag_b = req.b[OPND_W-1] ? neg_b[MAG_W-1:0] : req.b[MAG_W-1:0];

   always_comb begin
      prod_in = prod_ff;
      neg_in  = neg_ff;
      if (req.issue) begin
         prod_in = PROD_W'(mag_a) * PROD_W'(mag_b);
         neg_in  = req.a[OPND_W-1] ^ req.b[OPND_W-1];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
   end

   assign rnd    = (prod_ff + HALF) >> COV_FRAC_BITS;
   assign rmag   = rnd[MRES_W-1:0];
   assign result = neg_ff ? -$signed(rmag) : $signed(rmag);

endmodule

`default_nettype wire

// ===== hw/rtl/takf_div.sv =====
// takf_div: radix-2 restoring divider for the kalman gain, one quotient bit a cycle
// quotient carries COV_FRAC_BITS fraction bits, truncated and saturated; depends on takf_pkg
`default_nettype none

module takf_div import takf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   localparam int QB    = 32;
   localparam int CNT_W = $clog2(QB);
   localparam int NW    = QB + COV_FRAC_BITS;
   localparam int CW    = ((COV_FRAC_BITS > 33) ? COV_FRAC_BITS : 33) + 1;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [32:0]       rem_ff, rem_in;
   logic [QB-1:0]     lo_ff, lo_in;
   logic [QB-1:0]     q_ff, q_in;
   logic [32:0]       den_ff, den_in;
   logic              neg_ff, neg_in;
   logic              ovf_ff, ovf_in;

   logic [31:0]       num_neg;
   logic [31:0]       num_mag;
   logic [NW-1:0]     nshift;
   logic [CW-1:0]     hi_ext;
   logic [33:0]       trial;
   logic [33:0]       diff;
   logic              ge;
   logic [31:0]       q_neg;

   assign num_neg = -req.num;
   assign num_mag = req.num[31] ? num_neg : req.num;
   assign nshift  = NW'(num_mag) << COV_FRAC_BITS;
   assign hi_ext  = CW'(nshift[NW-1:QB]);

   assign trial = {rem_ff, lo_ff[QB-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      ovf_in  = ovf_ff;
      if (req.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QB - 1);
         rem_in  = hi_ext[32:0];
         lo_in   = nshift[QB-1:0];
         q_in    = '0;
         den_in  = req.den;
         neg_in  = req.num[31];
         ovf_in  = hi_ext >= CW'(req.den);
      end else if (busy_ff) begin
         rem_in = ge ? diff[32:0] : trial[32:0];
         lo_in  = lo_ff << 1;
         q_in   = {q_ff[QB-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      ovf_ff <= ovf_in;
   end

   assign q_neg    = -q_ff;
   assign rsp.done = done_ff;

   always_comb begin
      if (neg_ff) begin
         rsp.quotient = (ovf_ff || q_ff > 32'h8000_0000) ? S32_MIN : $signed(q_neg);
      end else begin
         rsp.quotient = (ovf_ff || q_ff[31]) ? S32_MAX : $signed(q_ff);
      end
   end

endmodule

`default_nettype wire
